@@ src/psra_pkg.sv @@
// Package: shared types and constants for the per-sensor running average block
`timescale 1ns / 1ps
`default_nettype none
package psra_pkg;
    localparam int MAX_SENSORS = 16;
    localparam int IDX_W = $clog2(MAX_SENSORS);
    localparam int CNT_W = $clog2(MAX_SENSORS + 1);

    localparam logic [1:0] ST_APPLIED = 2'd0;
    localparam logic [1:0] ST_STORED  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_MAX    = 2'd1;
    localparam logic [1:0] REG_MIN    = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_MEAS = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [15:0]        sens_id;
        logic [15:0]        room_id;
        logic signed [15:0] sample_value;
        logic [31:0]        sample_time;
    } t_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        room_of_sensor;
        logic signed [15:0] average_value;
        logic               window_full;
        logic               too_hot;
        logic               too_cold;
        logic [31:0]        last_seen_time;
    } t_result;
endpackage
`default_nettype wire

@@ src/psra_fifo.sv @@
// Two-entry queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module psra_fifo (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire psra_pkg::t_item  i_data,
    output logic                  o_valid,
    input  wire                   i_ready,
    output psra_pkg::t_item       o_data
);
    import psra_pkg::*;
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

@@ src/psra_front.sv @@
// Front part: input stage that unpacks beats into items
`timescale 1ns / 1ps
`default_nettype none
module psra_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire                   i_kind,
    input  wire [79:0]            i_data,
    output logic                  o_valid,
    input  wire                   i_ready,
    output psra_pkg::t_item       o_item
);
    import psra_pkg::*;
    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.kind         <= i_kind;
            r_item.sens_id      <= i_data[15:0];
            r_item.room_id      <= i_data[31:16];
            r_item.sample_value <= i_data[47:32];
            r_item.sample_time  <= i_data[79:48];
        end
        if (!i_rst_n) r_valid <= 1'b0;
        else if (o_ready) r_valid <= i_valid;
    end
endmodule
`default_nettype wire

@@ src/psra_div.sv @@
// Serial signed divider, truncating toward zero, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module psra_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire signed [23:0] i_num,
    input  wire [6:0]         i_den,
    output logic              o_done,
    output logic signed [23:0] o_quo
);
    logic [23:0] r_q, r_n;
    logic [7:0]  r_r;
    logic [6:0]  r_d;
    logic        r_neg, r_busy;
    logic [4:0]  r_i;
    logic [7:0]  w_tr;

    assign w_tr  = {r_r[6:0], r_n[23]};
    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);

    // o_done stays high from the end of a division until the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0;
        end else begin
            if (i_start) begin
                o_done <= 1'b0;
                r_busy <= 1'b1;
                r_i    <= 5'd0;
                r_neg  <= i_num[23];
                r_n    <= i_num[23] ? 24'(-i_num) : i_num;
                r_d    <= i_den;
                r_r    <= 8'd0;
                r_q    <= 24'd0;
            end else if (r_busy) begin
                r_n <= {r_n[22:0], 1'b0};
                if (w_tr >= {1'b0, r_d}) begin
                    r_r <= w_tr - {1'b0, r_d};
                    r_q <= {r_q[22:0], 1'b1};
                end else begin
                    r_r <= w_tr;
                    r_q <= {r_q[22:0], 1'b0};
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'd23) begin
                    r_busy <= 1'b0; o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ src/psra_back.sv @@
// Back part: table search, update and result register
`timescale 1ns / 1ps
`default_nettype none
module psra_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire psra_pkg::t_item  i_item,
    input  wire [6:0]             i_window,
    input  wire signed [15:0]     i_max,
    input  wire signed [15:0]     i_min,
    output logic                  o_valid,
    input  wire                   i_ready,
    output psra_pkg::t_result     o_res
);
    import psra_pkg::*;
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_SRCH = 6'b000010, S_READ = 6'b000100,
        S_DIV  = 6'b001000, S_WAIT = 6'b010000, S_OUT  = 6'b100000
    } t_state;

    t_state r_st;
    t_item  r_it;
    logic [CNT_W-1:0] r_used;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_scan;
    logic [15:0]        m_sensor [MAX_SENSORS];
    logic [15:0]        m_room   [MAX_SENSORS];
    logic [6:0]         m_count  [MAX_SENSORS];
    logic signed [22:0] m_sum    [MAX_SENSORS];
    logic signed [15:0] m_avg    [MAX_SENSORS];
    logic [15:0]        r_sens_rd;
    logic [15:0]        r_room;
    logic [6:0]         r_cnt;
    logic signed [22:0] r_sum;
    logic signed [15:0] r_avg;
    logic               r_smooth;
    logic [1:0]         r_code;
    logic [6:0]         w_w;
    logic               w_start, w_done;
    logic signed [23:0] w_num, w_quo, w_navg;
    logic [6:0]         w_den;
    logic               w_free, w_emit;
    logic               r_out_v;
    t_result            r_res;

    assign w_w     = (i_window == 7'd0) ? 7'd1 : i_window;
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_out_v;
    assign o_res   = r_res;
    assign w_start = (r_st == S_DIV);
    assign w_num   = r_smooth ? 24'($signed(r_it.sample_value)) - 24'(r_avg)
                              : 24'(r_sum) + 24'($signed(r_it.sample_value));
    assign w_den   = r_smooth ? w_w : r_cnt + 7'd1;
    assign w_navg  = r_smooth ? 24'(r_avg + w_quo) : w_quo;
    assign w_free  = !r_out_v || i_ready;
    assign w_emit  = (r_st == S_OUT) && w_free && ((r_code != ST_APPLIED) || w_done);

    psra_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_done), .o_quo(w_quo)
    );

    always_ff @(posedge i_clk) begin
        r_sens_rd <= m_sensor[r_scan[IDX_W-1:0]];
        r_room    <= m_room[r_idx];
        r_cnt     <= m_count[r_idx];
        r_sum     <= m_sum[r_idx];
        r_avg     <= m_avg[r_idx];
        if (r_st == S_IDLE && i_valid) r_it <= i_item;
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_used <= '0; r_out_v <= 1'b0; r_scan <= '0;
        end else begin
            if (w_emit) r_out_v <= 1'b1;
            else if (r_out_v && i_ready) r_out_v <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    r_scan <= '0;
                    if (i_valid) r_st <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_it.kind == KIND_LOAD) begin
                        if (r_used == CNT_W'(MAX_SENSORS)) r_code <= ST_FULL;
                        else begin
                            m_sensor[r_used[IDX_W-1:0]] <= r_it.sens_id;
                            m_room[r_used[IDX_W-1:0]]   <= r_it.room_id;
                            m_count[r_used[IDX_W-1:0]]  <= 7'd0;
                            m_sum[r_used[IDX_W-1:0]]    <= '0;
                            m_avg[r_used[IDX_W-1:0]]    <= '0;
                            r_used <= r_used + 1'b1;
                            r_code <= ST_STORED;
                        end
                        r_st <= S_OUT;
                    end else begin
                        // read data for scan-1 arrives this cycle; scan 0 is priming
                        if (r_scan != '0 && r_sens_rd == r_it.sens_id) begin
                            r_idx  <= IDX_W'(r_scan - 1'b1);
                            r_code <= ST_APPLIED;
                            r_st   <= S_READ;
                        end else if (r_scan == r_used) begin
                            r_code <= ST_UNKNOWN;
                            r_st <= S_OUT;
                        end else r_scan <= r_scan + 1'b1;
                    end
                end
                S_READ: begin
                    r_st <= S_WAIT;
                    r_smooth <= 1'b0;
                end
                S_WAIT: begin
                    r_smooth <= (r_cnt >= w_w);
                    r_st <= S_DIV;
                end
                S_DIV: r_st <= S_OUT;
                S_OUT: begin
                    if (w_emit) begin
                        if (r_code != ST_APPLIED) begin
                            // load, full table or unknown id: only status and room
                            r_res <= {r_code,
                                      (r_code == ST_STORED) ? r_it.room_id : 16'd0,
                                      51'd0};
                        end else begin
                            m_avg[r_idx] <= w_navg[15:0];
                            if (!r_smooth) begin
                                m_count[r_idx] <= r_cnt + 7'd1;
                                m_sum[r_idx]   <= 23'(w_num);
                            end
                            r_res.status <= ST_APPLIED;
                            r_res.room_of_sensor <= r_room;
                            r_res.average_value <= w_navg[15:0];
                            r_res.window_full <= r_smooth;
                            r_res.too_hot <= r_smooth && ($signed(w_navg[15:0]) > i_max);
                            r_res.too_cold <= r_smooth
                                              && !($signed(w_navg[15:0]) > i_max)
                                              && ($signed(w_navg[15:0]) < i_min);
                            r_res.last_seen_time <= r_it.sample_time;
                        end
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/per_sensor_running_average.sv @@
// Top level: per-sensor running average with threshold alarm
// Measurements take a linear table scan, one entry a cycle, then a 24-step serial divider;
// unknown ids take the scan alone, and loads neither.
// The back part takes one item at a time; the queue and input stage keep taking beats until full.
// Reset (synchronous, active low) empties the table and loads default registers.
`timescale 1ns / 1ps
`default_nettype none
module per_sensor_running_average (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [79:0] s_axis_tdata,  // sens_id, room_id, sample_value, sample_time
    input  wire        s_axis_tuser,  // kind
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [71:0] m_axis_tdata, // room_of_sensor, average_value, window_full,
                                      // too_hot, too_cold, last_seen_time, zero pad
    output logic [1:0] m_axis_tuser,  // status
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [1:0]  i_cfg_index,
    input  wire [15:0] i_cfg_data
);
    import psra_pkg::*;
    logic [6:0]         r_window;
    logic signed [15:0] r_max, r_min;
    logic  f_v, f_r, q_v, q_r;
    t_item f_it, q_it;
    t_result w_res;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= 7'd5; r_max <= 16'sd6400; r_min <= 16'sd3840;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WINDOW: r_window <= i_cfg_data[6:0];
                REG_MAX:    r_max <= i_cfg_data;
                REG_MIN:    r_min <= i_cfg_data;
                default: ;
            endcase
        end
    end

    psra_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_kind(s_axis_tuser), .i_data(s_axis_tdata),
        .o_valid(f_v), .i_ready(f_r), .o_item(f_it)
    );
    psra_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_v), .o_ready(f_r),
        .i_data(f_it), .o_valid(q_v), .i_ready(q_r), .o_data(q_it)
    );
    psra_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_v), .o_ready(q_r),
        .i_item(q_it), .i_window(r_window), .i_max(r_max), .i_min(r_min),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tuser = w_res.status;
    assign m_axis_tdata = {5'd0, w_res.last_seen_time, w_res.too_cold, w_res.too_hot,
                           w_res.window_full, w_res.average_value, w_res.room_of_sensor};
endmodule
`default_nettype wire
